// File: src/pidr_pkg.sv
// pidr_pkg: shared types, codes and encode/decode helpers for the pixel ID remap table.
// No dependencies; imported by pidr_cell and pixel_id_remap_table.
package pidr_pkg;

  localparam int unsigned PIX_W     = 21;
  localparam int unsigned IDX_W     = 8;
  localparam int unsigned ID_MAX_W  = 12;  // covers up to 4096 IDs
  localparam logic [PIX_W-1:0] BLANK_PIXEL = 21'd32;

  localparam logic [1:0] CMD_TRACK    = 2'd0;
  localparam logic [1:0] CMD_EMIT     = 2'd1;
  localparam logic [1:0] CMD_KEY_READ = 2'd2;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_NOT_TRACKED = 2'd1;
  localparam logic [1:0] ST_FULL        = 2'd2;
  localparam logic [1:0] ST_ID_RANGE    = 2'd3;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [PIX_W-1:0] pixel_value;
    logic [IDX_W-1:0] id_index;
  } pidr_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] encoded_char;
    logic [PIX_W-1:0] key_value;
    logic [IDX_W-1:0] highest_id;
    logic [1:0]       status;
  } pidr_out_t;

  // Query token walking down the cell chain.
  typedef struct packed {
    logic                valid;
    logic [1:0]          cmd;
    logic [PIX_W-1:0]    pixel;
    logic [ID_MAX_W-1:0] idx;
    logic                found;
    logic [ID_MAX_W-1:0] hit_id;
    logic [PIX_W-1:0]    key;
  } pidr_tok_t;

  // Broadcast write port into the chain.
  typedef struct packed {
    logic                en;
    logic [ID_MAX_W-1:0] addr;
    logic [PIX_W-1:0]    data;
  } pidr_wr_t;

  function automatic logic [PIX_W-1:0] utf_encode(input logic [ID_MAX_W-1:0] id);
    logic [PIX_W-1:0] e;
    e = PIX_W'(id) + 21'd32;
    if (e >= 21'd34) e = e + 21'd1;
    if (e >= 21'd92) e = e + 21'd1;
    return e;
  endfunction

  function automatic logic [PIX_W-1:0] utf_decode(input logic [PIX_W-1:0] cp);
    logic [PIX_W-1:0] d;
    d = cp;
    if (d >= 21'd93) d = d - 21'd1;
    if (d >= 21'd35) d = d - 21'd1;
    return d - 21'd32;
  endfunction

endpackage

// File: src/pidr_cell.sv
// pidr_cell: one dictionary entry plus one stage of the query token chain.
// Depends on pidr_pkg.
module pidr_cell import pidr_pkg::*; #(
  parameter int unsigned IDX = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [ID_MAX_W-1:0] last_id_i,
  input  pidr_wr_t            wr_i,
  input  pidr_tok_t           tok_i,
  output pidr_tok_t           tok_o
);

  localparam logic [ID_MAX_W-1:0] MyId = ID_MAX_W'(IDX);

  logic [PIX_W-1:0] entry_q;
  pidr_tok_t        tok_d, tok_q;
  logic             active, match, wr_hit;

  assign active = (MyId <= last_id_i);
  assign match  = tok_i.valid && active && !tok_i.found && (entry_q == tok_i.pixel);
  assign wr_hit = wr_i.en && (wr_i.addr == MyId);

  always_comb begin
    tok_d = tok_i;
    if (match) begin
      tok_d.found  = 1'b1;
      tok_d.hit_id = MyId;
    end
    if (tok_i.valid && (tok_i.idx == MyId)) begin
      tok_d.key = entry_q;
    end
  end

  // entry 0 holds the empty pixel from reset; the others are written before use
  if (IDX == 0) begin : g_init
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        entry_q <= BLANK_PIXEL;
      end else if (wr_hit) begin
        entry_q <= wr_i.data;
      end
    end
  end else begin : g_plain
    always_ff @(posedge clk_i) begin
      if (wr_hit) begin
        entry_q <= wr_i.data;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

// File: src/pixel_id_remap_table.sv
// pixel_id_remap_table: top level, first-seen ID dictionary for rendered pixel values.
// Depends on pidr_pkg and pidr_cell.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o, in_data_i) carries one command per
//   transaction: track, emit or key read. Output channel (out_valid_o/
//   out_ready_i, out_data_o) returns exactly one result per command.
//   Each entry lives in its own cell; a query token enters cell 0 on accept
//   and advances one cell per cycle, picking up the first matching ID and the
//   entry at id_index on the way. At the chain end the result is finished and
//   a track of a new pixel writes the next free cell, if one is left.
//   A result passes from the last cell to the holding register and then to the
//   output register. The next command is taken only once the last one has left
//   the chain and the holding register; one command is in flight at a time.
//   A finished result waits in a holding register while the output register
//   is stalled, and the next command is still taken as soon as the chain and
//   the holding register are free. out_data_o holds steady while stalled.
//   Reset: ID 0 maps to the empty pixel 32, highest ID is 0, no transaction
//   is pending. No clearing pass is needed.
module pixel_id_remap_table import pidr_pkg::*; #(
  parameter int unsigned MAX_IDS = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  pidr_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output pidr_out_t out_data_o
);

  localparam int unsigned ID_W = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;
  localparam logic [ID_W-1:0] LastSlot = ID_W'(MAX_IDS - 1);

  pidr_tok_t tok [MAX_IDS+1];
  pidr_wr_t  wr;

  logic                busy_q, pend_valid_q, out_valid_q;
  logic [ID_W-1:0]     last_id_q, last_id_d;
  logic [ID_MAX_W-1:0] last_ext, last_new_ext, next_id_ext;
  pidr_out_t           pend_q, out_q, res;
  logic                in_fire, end_valid, move_out;

  assign in_ready_o = !busy_q && !pend_valid_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign end_valid  = tok[MAX_IDS].valid;
  assign move_out   = pend_valid_q && (!out_valid_q || out_ready_i);

  // token injected straight from the input transaction
  always_comb begin
    tok[0].valid  = in_fire;
    tok[0].cmd    = in_data_i.cmd;
    tok[0].pixel  = in_data_i.pixel_value;
    tok[0].idx    = ID_MAX_W'(in_data_i.id_index);
    tok[0].found  = 1'b0;
    tok[0].hit_id = '0;
    tok[0].key    = '0;
  end

  assign last_ext    = ID_MAX_W'(last_id_q);
  assign next_id_ext = last_ext + ID_MAX_W'(1);

  for (genvar i = 0; i < MAX_IDS; i++) begin : g_cell
    pidr_cell #(.IDX(i)) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .last_id_i (last_ext),
      .wr_i      (wr),
      .tok_i     (tok[i]),
      .tok_o     (tok[i+1])
    );
  end

  // Result and insert decision at the chain end
  always_comb begin
    res          = '0;
    last_id_d    = last_id_q;
    wr.en        = 1'b0;
    wr.addr      = next_id_ext;
    wr.data      = tok[MAX_IDS].pixel;
    case (tok[MAX_IDS].cmd)
      CMD_TRACK: begin
        if (tok[MAX_IDS].found) begin
          res.encoded_char = utf_encode(tok[MAX_IDS].hit_id);
        end else if (last_id_q == LastSlot) begin
          res.status = ST_FULL;
        end else begin
          wr.en            = end_valid;
          last_id_d        = last_id_q + ID_W'(1);
          res.encoded_char = utf_encode(next_id_ext);
        end
      end
      CMD_EMIT: begin
        if (tok[MAX_IDS].found) begin
          res.encoded_char = utf_encode(tok[MAX_IDS].hit_id);
        end else begin
          res.status = ST_NOT_TRACKED;
        end
      end
      CMD_KEY_READ: begin
        if (tok[MAX_IDS].idx > last_ext) begin
          res.status = ST_ID_RANGE;
        end else begin
          res.key_value = utf_decode(tok[MAX_IDS].key);
        end
      end
      default: begin
        res.status = ST_OK;
      end
    endcase
    last_new_ext   = ID_MAX_W'(last_id_d);
    res.highest_id = last_new_ext[IDX_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      last_id_q    <= '0;
    end else begin
      if (in_fire) begin
        busy_q <= 1'b1;
      end else if (end_valid) begin
        busy_q <= 1'b0;
      end
      if (end_valid) begin
        last_id_q    <= last_id_d;
        pend_valid_q <= 1'b1;
      end else if (move_out) begin
        pend_valid_q <= 1'b0;
      end
      if (move_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (end_valid) begin
      pend_q <= res;
    end
    if (move_out) begin
      out_q <= pend_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
